// ----- rtl/flash_program_erase_store_macros.svh -----
// Assertion macros for the flash program/erase store.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef FLASH_PROGRAM_ERASE_STORE_MACROS_SVH
`define FLASH_PROGRAM_ERASE_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fpes_pkg.sv -----
// Shared types, constants and helpers for the flash program/erase store.
// Used by the top level and the address checker; depends on nothing else.
`default_nettype none

package fpes_pkg;

	localparam int unsigned PAGE_BYTES = 1024;
	localparam int unsigned PAGE_COUNT = 4;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 16;

	localparam int unsigned REGION_BYTES = PAGE_BYTES * PAGE_COUNT;
	localparam int unsigned DEPTH = (REGION_BYTES + 1) / 2;
	localparam int unsigned AW = $clog2(DEPTH);

	// Exact reciprocal of the page size for any address of ADDR_W bits.
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int unsigned RECIP_SHIFT = ADDR_W + PAGE_SHIFT;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + longint'(PAGE_BYTES) - 64'd1) / longint'(PAGE_BYTES);
	localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
	localparam int unsigned PROD_W = ADDR_W + RECIP_W;

	localparam logic [DATA_W-1:0] ERASED = 16'hFFFF;
	localparam logic [DATA_W-1:0] LOW_MASK = 16'h00FF;
	localparam logic [DATA_W-1:0] HIGH_MASK = 16'hFF00;

	typedef enum logic [2:0] {
		OP_RD_HALF = 3'd0,
		OP_RD_BYTE = 3'd1,
		OP_PRG_HALF = 3'd2,
		OP_PRG_BYTE = 3'd3,
		OP_ERASE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ALIGN = 2'd1,
		ST_BADADDR = 2'd2,
		ST_PROGERR = 2'd3
	} status_t;

	typedef struct packed {
		logic odd;
		logic in_range;
		logic page_aligned;
	} addr_chk_t;

	function automatic logic [AW-1:0] half_index(input logic [ADDR_W-1:0] byte_addr);
		return AW'(byte_addr >> 1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/flash_program_erase_store.sv -----
// Top level of the flash program/erase store: sequencer, result register and RAM.
// Uses fpes_pkg, fpes_ram, fpes_addr_chk and the assertion macro header.
`default_nettype none

`include "flash_program_erase_store_macros.svh"

// A read or program request first reads the halfword from the single-port RAM and
// then checks it and writes it back; a new request is taken only once the previous
// one has loaded its result into the result register.
// A page erase writes one halfword a cycle through the RAM port. After reset
// the block first sets the whole array to all ones, one halfword a cycle; no request
// is taken until then.
// The result register lets the next request be taken while a result still waits.
module flash_program_erase_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [2:0]                    operation,
	input  wire logic [fpes_pkg::ADDR_W-1:0]   address,
	input  wire logic [fpes_pkg::DATA_W-1:0]   write_data,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         status,
	output logic [fpes_pkg::DATA_W-1:0]        read_data
);

	localparam int unsigned AW = fpes_pkg::AW;
	localparam int unsigned DW = fpes_pkg::DATA_W;
	localparam int unsigned AD_W = fpes_pkg::ADDR_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_CHECK = 5'b00100,
		S_ERASE = 5'b01000,
		S_HOLD  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [2:0]      op_q;
	logic [AD_W-1:0] addr_q;
	logic [DW-1:0]   data_q;
	logic [AW-1:0]   walk_q;
	logic [AW-1:0]   walk_last_q;
	logic            res_valid_q;
	fpes_pkg::status_t res_status_q;
	logic [DW-1:0]   res_data_q;
	fpes_pkg::status_t pend_status_q;
	logic [DW-1:0]   pend_data_q;

	logic            req_accept;
	logic            res_free;
	logic            res_load;
	logic            walk_start;
	logic            walk_step;
	logic [AW-1:0]   erase_last;

	logic            ram_en;
	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [DW-1:0]   ram_wdata;
	logic [DW-1:0]   ram_rdata;

	fpes_pkg::addr_chk_t chk;

	fpes_pkg::status_t chk_status;
	logic [DW-1:0]   chk_data;
	logic            chk_write;
	logic [DW-1:0]   chk_wdata;
	logic            chk_erase;

	logic            fin;
	fpes_pkg::status_t fin_status;
	logic [DW-1:0]   fin_data;

	assign req_stall = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign res_free = !res_valid_q || !res_stall;
	assign erase_last = AW'((32'(addr_q) + fpes_pkg::PAGE_BYTES - 32'd1) >> 1);

	fpes_addr_chk u_addr_chk (
		.clk     (clk),
		.capture (req_accept),
		.address (address),
		.chk     (chk)
	);

	fpes_ram #(
		.WIDTH (DW),
		.DEPTH (fpes_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		chk_status = fpes_pkg::ST_OK;
		chk_data = '0;
		chk_write = 1'b0;
		chk_wdata = data_q;
		chk_erase = 1'b0;
		case (fpes_pkg::op_t'(op_q))
			fpes_pkg::OP_RD_HALF: begin
				if (chk.odd) begin
					chk_status = fpes_pkg::ST_ALIGN;
				end else if (!chk.in_range) begin
					chk_status = fpes_pkg::ST_BADADDR;
				end else begin
					chk_data = ram_rdata;
				end
			end
			fpes_pkg::OP_RD_BYTE: begin
				if (!chk.in_range) begin
					chk_status = fpes_pkg::ST_BADADDR;
				end else if (chk.odd) begin
					chk_data = {8'h00, ram_rdata[15:8]};
				end else begin
					chk_data = {8'h00, ram_rdata[7:0]};
				end
			end
			fpes_pkg::OP_PRG_HALF: begin
				if (chk.odd) begin
					chk_status = fpes_pkg::ST_ALIGN;
				end else if (!chk.in_range) begin
					chk_status = fpes_pkg::ST_BADADDR;
				end else if (ram_rdata != fpes_pkg::ERASED) begin
					chk_status = fpes_pkg::ST_PROGERR;
				end else begin
					chk_write = 1'b1;
				end
			end
			fpes_pkg::OP_PRG_BYTE: begin
				if (chk.odd) begin
					chk_wdata = (ram_rdata & fpes_pkg::LOW_MASK) | {data_q[7:0], 8'h00};
				end else begin
					chk_wdata = (ram_rdata & fpes_pkg::HIGH_MASK) | {8'h00, data_q[7:0]};
				end
				if (!chk.in_range) begin
					chk_status = fpes_pkg::ST_BADADDR;
				end else if (ram_rdata != fpes_pkg::ERASED) begin
					chk_status = fpes_pkg::ST_PROGERR;
				end else begin
					chk_write = 1'b1;
				end
			end
			fpes_pkg::OP_ERASE: begin
				if (!chk.page_aligned) begin
					chk_status = fpes_pkg::ST_ALIGN;
				end else if (!chk.in_range) begin
					chk_status = fpes_pkg::ST_BADADDR;
				end else begin
					chk_erase = 1'b1;
				end
			end
			default: begin
				chk_status = fpes_pkg::ST_BADADDR;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		ram_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = walk_q;
		ram_wdata = fpes_pkg::ERASED;
		walk_start = 1'b0;
		walk_step = 1'b0;
		fin = 1'b0;
		fin_status = fpes_pkg::ST_OK;
		fin_data = '0;
		res_load = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				if (walk_q == walk_last_q) begin
					state_d = S_IDLE;
				end else begin
					walk_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (req_accept) begin
					ram_en = 1'b1;
					ram_addr = fpes_pkg::half_index(address);
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (chk_write) begin
					ram_en = 1'b1;
					ram_we = 1'b1;
					ram_addr = fpes_pkg::half_index(addr_q);
					ram_wdata = chk_wdata;
				end
				if (chk_erase) begin
					walk_start = 1'b1;
					state_d = S_ERASE;
				end else begin
					fin = 1'b1;
					fin_status = chk_status;
					fin_data = chk_data;
				end
			end
			S_ERASE: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				if (walk_q == walk_last_q) begin
					fin = 1'b1;
				end else begin
					walk_step = 1'b1;
				end
			end
			S_HOLD: begin
				fin = 1'b1;
				fin_status = pend_status_q;
				fin_data = pend_data_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			if (res_free) begin
				res_load = 1'b1;
				state_d = S_IDLE;
			end else begin
				state_d = S_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			walk_q <= '0;
			walk_last_q <= AW'(fpes_pkg::DEPTH - 1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (walk_start) begin
				walk_q <= fpes_pkg::half_index(addr_q);
				walk_last_q <= erase_last;
			end else if (walk_step) begin
				walk_q <= walk_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_q <= operation;
			addr_q <= address;
			data_q <= write_data;
		end
		if (res_load) begin
			res_status_q <= fin_status;
			res_data_q <= fin_data;
		end
		if (fin && !res_free) begin
			pend_status_q <= fin_status;
			pend_data_q <= fin_data;
		end
	end

	assign res_valid = res_valid_q;
	assign status = res_status_q;
	assign read_data = res_data_q;

	`FPES_ASSERT_SAME(a_no_write_idle, state_q == S_IDLE, !ram_we, "RAM written while idle")
	`FPES_ASSERT_NEXT(a_accept_to_check, req_accept, state_q == S_CHECK, "accept not followed by check")
	`FPES_ASSERT_SAME(a_walk_bound, state_q == S_ERASE, walk_q <= walk_last_q, "erase walk overran page")
	`FPES_ASSERT_SAME(a_no_result_clear, state_q == S_CLEAR, !res_load, "result during clearing pass")

endmodule

`default_nettype wire

// ----- rtl/fpes_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; holds the halfword array of the store.
`default_nettype none

module fpes_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fpes_addr_chk.sv -----
// Address checker: parity, region range and page alignment of a request address.
// Uses fpes_pkg; alignment comes from a registered reciprocal multiply.
`default_nettype none

module fpes_addr_chk (
	input  wire logic                          clk,
	input  wire logic                          capture,
	input  wire logic [fpes_pkg::ADDR_W-1:0]   address,
	output fpes_pkg::addr_chk_t                chk
);

	localparam int unsigned AD_W = fpes_pkg::ADDR_W;
	localparam int unsigned PW = fpes_pkg::PROD_W;

	logic [PW-1:0]   prod;
	logic [AD_W-1:0] quot;
	logic [AD_W-1:0] addr_s1;
	logic [AD_W-1:0] quot_s1;
	logic            odd_s1;
	logic            in_range_s1;
	logic [31:0]     page_base;

	assign prod = PW'(address) * PW'(fpes_pkg::RECIP);
	assign quot = AD_W'(prod >> fpes_pkg::RECIP_SHIFT);

	always_ff @(posedge clk) begin
		if (capture) begin
			addr_s1 <= address;
			quot_s1 <= quot;
			odd_s1 <= address[0];
			in_range_s1 <= (32'(address) < fpes_pkg::REGION_BYTES);
		end
	end

	assign page_base = 32'(quot_s1) * fpes_pkg::PAGE_BYTES;

	assign chk.odd = odd_s1;
	assign chk.in_range = in_range_s1;
	assign chk.page_aligned = (page_base == 32'(addr_s1));

endmodule

`default_nettype wire
